### sv/csvt_pkg.sv
// Package for the CSV record tokenizer: result kinds, item function codes,
// byte constants and the control-flag struct shared by core and top level.
// No dependencies.
package csvt_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOF  = 2'd1,
        KIND_EOR  = 2'd2
    } t_kind;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOI  = 1'b1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef struct packed {
        logic inside_quotes;
        logic quote_pending;
        logic record_open;
    } t_flags;

endpackage

### sv/csvt_if.sv
// Stream interfaces for the CSV record tokenizer: input words and result words.
// Depends on csvt_pkg for the result kind type.
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface csvt_out_if;
    logic             valid;
    logic             ready;
    csvt_pkg::t_kind  kind;
    logic [7:0]       out_byte;
    logic [7:0]       field_index;

    modport source (output valid, output kind, output out_byte, output field_index,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input field_index,
                    output ready);
endinterface

### sv/csv_record_tokenizer_unit.sv
// CSV record tokenizer, top level: input register, step logic, result register.
// Depends on csvt_pkg, csvt_if (csvt_in_if, csvt_out_if) and csvt_core.
//
// Splits a byte stream into fields and records with RFC 4180 quoting and a
// programmable delimiter (reset value comma). One word is accepted per clock
// while the result register is free or being read; each word gives at most one
// result word, which passes the input register, then the combinational step
// logic into the result register. The throughput of one word per cycle is held
// while the result register drains, since the input register advances whenever
// the result register is free or being read. Write the delimiter only while no
// words are in flight.
module csv_record_tokenizer_unit #(
    parameter int MAX_FIELDS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    csvt_in_if.sink            i_in,
    csvt_out_if.source         o_out
);

    localparam int COL_SAT = (MAX_FIELDS - 1 > 255) ? 255 : (MAX_FIELDS - 1);
    localparam int COL_W   = $clog2(COL_SAT + 1);

    logic [7:0]        r_delim;
    logic              r_s1_valid;
    logic              r_s1_func;
    logic [7:0]        r_s1_byte;
    csvt_pkg::t_flags  r_flags, n_flags;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_out_valid;
    csvt_pkg::t_kind   r_out_kind;
    logic [7:0]        r_out_byte;
    logic [7:0]        r_out_index;

    logic              res_valid;
    csvt_pkg::t_kind   res_kind;
    logic [7:0]        res_byte;
    logic [7:0]        res_index;
    logic              advance;

    assign advance    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || advance;

    csvt_core #(
        .COL_W   (COL_W),
        .COL_SAT (COL_SAT)
    ) u_core (
        .i_flags     (r_flags),
        .i_col       (r_col),
        .i_delim     (r_delim),
        .i_func      (r_s1_func),
        .i_byte      (r_s1_byte),
        .o_flags     (n_flags),
        .o_col       (n_col),
        .o_res_valid (res_valid),
        .o_res_kind  (res_kind),
        .o_res_byte  (res_byte),
        .o_res_index (res_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= csvt_pkg::CH_COMMA;
            r_s1_valid  <= 1'b0;
            r_flags     <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_delim <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (advance) begin
                r_flags <= n_flags;
                r_col   <= n_col;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_func <= i_in.func;
            r_s1_byte <= i_in.data_byte;
        end
        if (advance) begin
            r_out_kind  <= res_kind;
            r_out_byte  <= res_byte;
            r_out_index <= res_index;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.field_index = r_out_index;

    // a pending quote only ever exists inside a quoted section
    a_pending_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.quote_pending |-> r_flags.inside_quotes)
        else $error("quote pending outside quotes");

    a_col_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COL_SAT))
        else $error("column count above saturation");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s1_func == csvt_pkg::FUNC_EOI)
        |=> (r_flags == '0 && r_col == '0))
        else $error("end of input did not clear state");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != csvt_pkg::KIND_BYTE) |-> r_out_byte == 8'd0)
        else $error("field marker carries a nonzero byte");

endmodule

### sv/csvt_core.sv
// Tokenizer step logic: from the current flags, column and one input word it
// works out the next flags and column and the result word, if any.
// Depends on csvt_pkg.
module csvt_core #(
    parameter int COL_W   = 8,
    parameter int COL_SAT = 255
) (
    input  csvt_pkg::t_flags   i_flags,
    input  logic [COL_W-1:0]   i_col,
    input  logic [7:0]         i_delim,
    input  logic               i_func,
    input  logic [7:0]         i_byte,
    output csvt_pkg::t_flags   o_flags,
    output logic [COL_W-1:0]   o_col,
    output logic               o_res_valid,
    output csvt_pkg::t_kind    o_res_kind,
    output logic [7:0]         o_res_byte,
    output logic [7:0]         o_res_index
);

    logic unq;  // byte goes through the unquoted rules

    always_comb begin
        o_flags     = i_flags;
        o_col       = i_col;
        o_res_valid = 1'b0;
        o_res_kind  = csvt_pkg::KIND_BYTE;
        o_res_byte  = 8'd0;
        o_res_index = 8'(i_col);
        unq         = 1'b0;

        if (i_func == csvt_pkg::FUNC_EOI) begin
            o_res_valid = i_flags.record_open;
            o_res_kind  = csvt_pkg::KIND_EOR;
            o_flags     = '0;
            o_col       = '0;
        end else if (i_flags.quote_pending) begin
            o_flags.quote_pending = 1'b0;
            if (i_byte == csvt_pkg::CH_QUOTE) begin
                o_res_valid = 1'b1;
                o_res_byte  = csvt_pkg::CH_QUOTE;
            end else begin
                o_flags.inside_quotes = 1'b0;
                unq = 1'b1;
            end
        end else if (i_flags.inside_quotes) begin
            if (i_byte == csvt_pkg::CH_QUOTE) begin
                o_flags.quote_pending = 1'b1;
            end else begin
                o_res_valid = 1'b1;
                o_res_byte  = i_byte;
            end
        end else begin
            unq = 1'b1;
        end

        // quote wins over delimiter, delimiter over CR and LF
        if (unq) begin
            o_flags.record_open = 1'b1;
            if (i_byte == csvt_pkg::CH_QUOTE) begin
                o_flags.inside_quotes = 1'b1;
            end else if (i_byte == i_delim) begin
                o_res_valid = 1'b1;
                o_res_kind  = csvt_pkg::KIND_EOF;
                if (i_col < COL_W'(COL_SAT)) begin
                    o_col = i_col + COL_W'(1);
                end
            end else if (i_byte == csvt_pkg::CH_CR) begin
                o_res_valid = 1'b0;
            end else if (i_byte == csvt_pkg::CH_LF) begin
                o_res_valid         = 1'b1;
                o_res_kind          = csvt_pkg::KIND_EOR;
                o_col               = '0;
                o_flags.record_open = 1'b0;
            end else begin
                o_res_valid = 1'b1;
                o_res_byte  = i_byte;
            end
        end
    end

endmodule
